FILE: rtl/assert_macros.svh
// Assertion macros for the checker file hrlp_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define HRLP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define HRLP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/hrlp_pkg.sv
// Types, constants and helpers shared by the request line parser.
package hrlp_pkg;

  localparam int MAX_LINE_DEF = 1024;
  localparam int OFS_W        = 10;
  localparam int LEN_W        = 11;
  localparam int IN_TDATA_W   = 8;
  localparam int OUT_FIELDS_W = 106;
  localparam int OUT_TDATA_W  = 112;

  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_H     = 8'h68;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_P     = 8'h70;

  localparam logic [2:0] PREFIX_LEN = 3'd7;
  localparam logic [2:0] TOK_PATH   = 3'd1;
  localparam logic [2:0] TOK_ALL    = 3'd3;
  localparam logic [2:0] TOK_SAT    = 3'd4;

  typedef enum logic [1:0] {
    PH_MATCH  = 2'd0,
    PH_SERVER = 2'd1,
    PH_FOUND  = 2'd2,
    PH_NONE   = 2'd3
  } phase_t;

  typedef struct packed {
    logic             fail;
    logic [LEN_W-1:0] cmd_start;
    logic [LEN_W-1:0] cmd_len;
    logic [LEN_W-1:0] path_start;
    logic [LEN_W-1:0] path_len;
    logic [LEN_W-1:0] prot_start;
    logic [LEN_W-1:0] prot_len;
    logic             srv_found;
    logic [LEN_W-1:0] srv_start;
    logic [LEN_W-1:0] srv_slash;
    logic [LEN_W-1:0] srv_colon;
    logic             port_ok;
    logic [LEN_W-1:0] port_begin;
  } snap_t;

  function automatic logic is_sep(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_LF) || (b == CH_CR) || (b == CH_TAB);
  endfunction

  function automatic logic [7:0] prefix_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0: c = CH_H;
      3'd1: c = CH_T;
      3'd2: c = CH_T;
      3'd3: c = CH_P;
      3'd4: c = CH_COLON;
      3'd5: c = CH_SLASH;
      3'd6: c = CH_SLASH;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/hrlp_scan.sv
// Input stage, running token and server state, and end-of-buffer snapshot.
module hrlp_scan #(
  parameter int MAX_LINE = hrlp_pkg::MAX_LINE_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [hrlp_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                             in_tlast,
  output logic                             fin_vld,
  input  logic                             fin_take,
  output hrlp_pkg::snap_t                  fin_snap
);

  localparam int IDX_W = $clog2(MAX_LINE + 1);
  localparam logic [IDX_W-1:0] LINE_LIM = IDX_W'(MAX_LINE);
  localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);

  logic             in_vld_r;
  logic [7:0]       byte_r;
  logic             eob_r;
  logic             proc;

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [2:0]       tc_r, tc_nxt;
  logic             inside_r, inside_nxt;
  logic             done_r, done_nxt;
  logic             ovf_r, ovf_nxt;
  logic [IDX_W-1:0] tb_start_r [3];
  logic [IDX_W-1:0] tb_start_nxt [3];
  logic [IDX_W-1:0] tb_len_r [3];
  logic [IDX_W-1:0] tb_len_nxt [3];
  logic [2:0]       prog_r, prog_nxt;
  hrlp_pkg::phase_t phase_r, phase_nxt;
  logic [IDX_W-1:0] srv_start_r, srv_start_nxt;
  logic [IDX_W-1:0] srv_slash_r, srv_slash_nxt;
  logic [IDX_W-1:0] srv_colon_r, srv_colon_nxt;
  logic             colon_r, colon_nxt;
  logic             pact_r, pact_nxt;
  logic [IDX_W-1:0] pbeg_r, pbeg_nxt;

  logic             fin_vld_r;
  hrlp_pkg::snap_t  snap_r, snap_nxt;

  logic             sep;
  logic             tok_open;
  logic             tok_close;

  assign proc      = in_vld_r && (!eob_r || !fin_vld_r || fin_take);
  assign in_tready = !in_vld_r || proc;
  assign fin_vld   = fin_vld_r;
  assign fin_snap  = snap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      byte_r <= in_tdata;
      eob_r  <= in_tlast;
    end
  end

  always_comb begin
    idx_nxt       = idx_r;
    tc_nxt        = tc_r;
    inside_nxt    = inside_r;
    done_nxt      = done_r;
    ovf_nxt       = ovf_r;
    tb_start_nxt  = tb_start_r;
    tb_len_nxt    = tb_len_r;
    prog_nxt      = prog_r;
    phase_nxt     = phase_r;
    srv_start_nxt = srv_start_r;
    srv_slash_nxt = srv_slash_r;
    srv_colon_nxt = srv_colon_r;
    colon_nxt     = colon_r;
    pact_nxt      = pact_r;
    pbeg_nxt      = pbeg_r;
    sep           = hrlp_pkg::is_sep(byte_r);
    tok_open      = !inside_r && !sep;
    tok_close     = inside_r && sep;

    if (!done_r) begin
      if (idx_r >= LINE_LIM) begin
        ovf_nxt = 1'b1;
      end else begin
        idx_nxt = idx_r + IDX_ONE;
        if (tok_open) begin
          inside_nxt = 1'b1;
          for (int k = 0; k < 3; k++) begin
            if (tc_r == 3'(k)) tb_start_nxt[k] = idx_r;
          end
          if (tc_r == hrlp_pkg::TOK_PATH) begin
            prog_nxt  = 3'd0;
            phase_nxt = hrlp_pkg::PH_MATCH;
            colon_nxt = 1'b0;
            pact_nxt  = 1'b0;
          end
        end else if (tok_close) begin
          inside_nxt = 1'b0;
          for (int k = 0; k < 3; k++) begin
            if (tc_r == 3'(k)) tb_len_nxt[k] = idx_r - tb_start_r[k];
          end
          if (tc_r < hrlp_pkg::TOK_SAT) tc_nxt = tc_r + 3'd1;
        end

        if (inside_nxt && (tc_nxt == hrlp_pkg::TOK_PATH)) begin
          case (phase_nxt)
            hrlp_pkg::PH_MATCH: begin
              if ((prog_nxt < hrlp_pkg::PREFIX_LEN) &&
                  (byte_r == hrlp_pkg::prefix_char(prog_nxt))) begin
                prog_nxt = prog_nxt + 3'd1;
                if (prog_nxt == hrlp_pkg::PREFIX_LEN) begin
                  phase_nxt     = hrlp_pkg::PH_SERVER;
                  srv_start_nxt = idx_r + IDX_ONE;
                end
              end else begin
                phase_nxt = hrlp_pkg::PH_NONE;
              end
            end
            hrlp_pkg::PH_SERVER: begin
              if (byte_r == hrlp_pkg::CH_SLASH) begin
                srv_slash_nxt = idx_r;
                phase_nxt     = hrlp_pkg::PH_FOUND;
              end else if (byte_r == hrlp_pkg::CH_COLON) begin
                if (!colon_nxt) begin
                  colon_nxt     = 1'b1;
                  srv_colon_nxt = idx_r;
                end
                pbeg_nxt = idx_r + IDX_ONE;
                pact_nxt = 1'b1;
              end else if ((byte_r < hrlp_pkg::CH_ZERO) || (byte_r > hrlp_pkg::CH_NINE)) begin
                pact_nxt = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end

        if (byte_r == hrlp_pkg::CH_LF) done_nxt = 1'b1;
      end
    end

    snap_nxt.fail       = ovf_nxt || (tc_nxt != hrlp_pkg::TOK_ALL) || inside_nxt;
    snap_nxt.cmd_start  = hrlp_pkg::LEN_W'(tb_start_nxt[0]);
    snap_nxt.cmd_len    = hrlp_pkg::LEN_W'(tb_len_nxt[0]);
    snap_nxt.path_start = hrlp_pkg::LEN_W'(tb_start_nxt[1]);
    snap_nxt.path_len   = hrlp_pkg::LEN_W'(tb_len_nxt[1]);
    snap_nxt.prot_start = hrlp_pkg::LEN_W'(tb_start_nxt[2]);
    snap_nxt.prot_len   = hrlp_pkg::LEN_W'(tb_len_nxt[2]);
    snap_nxt.srv_found  = (phase_nxt == hrlp_pkg::PH_FOUND);
    snap_nxt.srv_start  = hrlp_pkg::LEN_W'(srv_start_nxt);
    snap_nxt.srv_slash  = hrlp_pkg::LEN_W'(srv_slash_nxt);
    snap_nxt.srv_colon  = hrlp_pkg::LEN_W'(srv_colon_nxt);
    snap_nxt.port_ok    = colon_nxt && pact_nxt && (srv_slash_nxt > pbeg_nxt);
    snap_nxt.port_begin = hrlp_pkg::LEN_W'(pbeg_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (proc && eob_r)) begin
      idx_r       <= '0;
      tc_r        <= '0;
      inside_r    <= 1'b0;
      done_r      <= 1'b0;
      ovf_r       <= 1'b0;
      tb_start_r  <= '{default: '0};
      tb_len_r    <= '{default: '0};
      prog_r      <= '0;
      phase_r     <= hrlp_pkg::PH_MATCH;
      srv_start_r <= '0;
      srv_slash_r <= '0;
      srv_colon_r <= '0;
      colon_r     <= 1'b0;
      pact_r      <= 1'b0;
      pbeg_r      <= '0;
    end else if (proc) begin
      idx_r       <= idx_nxt;
      tc_r        <= tc_nxt;
      inside_r    <= inside_nxt;
      done_r      <= done_nxt;
      ovf_r       <= ovf_nxt;
      tb_start_r  <= tb_start_nxt;
      tb_len_r    <= tb_len_nxt;
      prog_r      <= prog_nxt;
      phase_r     <= phase_nxt;
      srv_start_r <= srv_start_nxt;
      srv_slash_r <= srv_slash_nxt;
      srv_colon_r <= srv_colon_nxt;
      colon_r     <= colon_nxt;
      pact_r      <= pact_nxt;
      pbeg_r      <= pbeg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_vld_r <= 1'b0;
    end else if (proc && eob_r) begin
      fin_vld_r <= 1'b1;
    end else if (fin_take) begin
      fin_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && eob_r) snap_r <= snap_nxt;
  end

endmodule

FILE: rtl/http_request_line_parser_top.sv
// Results: the end_of_buffer beat passes the input register, the snapshot and the out_ register.
// Throughput: one byte per cycle through the input register, the parse state update and the
// output register; only a final byte waits on a full snapshot.
// Reset: rst_n (synchronous, active low) clears all parse state and empties the outputs.
// The final byte of each buffer also returns the parser to its reset state.
module http_request_line_parser_top #(
  parameter int MAX_LINE = hrlp_pkg::MAX_LINE_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [hrlp_pkg::IN_TDATA_W-1:0]   in_tdata,   // line_byte
  input  logic                              in_tlast,   // end_of_buffer
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // command_start, command_length, path_start, path_length, protocol_start,
  // protocol_length, server_found, server_start, server_length, port_start,
  // port_length, zero fill
  output logic [hrlp_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic [0:0]                        out_tuser   // parse_status
);

  localparam int OW = hrlp_pkg::OFS_W;
  localparam int LW = hrlp_pkg::LEN_W;

  logic             fin_vld;
  logic             fin_take;
  hrlp_pkg::snap_t  snap;
  logic             out_free;

  logic             out_tvalid_r;
  logic [hrlp_pkg::OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic             status_r, status_nxt;

  logic [LW-1:0]    srv_len;
  logic [LW-1:0]    path_start;
  logic [LW-1:0]    path_len;
  logic [LW-1:0]    port_start;
  logic [LW-1:0]    port_len;

  hrlp_scan #(
    .MAX_LINE (MAX_LINE)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .fin_vld   (fin_vld),
    .fin_take  (fin_take),
    .fin_snap  (snap)
  );

  assign out_free = !out_tvalid_r || out_tready;
  assign fin_take = fin_vld && out_free;

  always_comb begin
    srv_len    = '0;
    path_start = snap.path_start;
    path_len   = snap.path_len;
    port_start = '0;
    port_len   = '0;
    if (snap.srv_found) begin
      srv_len    = snap.srv_slash - snap.srv_start;
      path_len   = snap.path_start + snap.path_len - snap.srv_slash;
      path_start = snap.srv_slash;
      if (snap.port_ok) begin
        srv_len    = snap.srv_colon - snap.srv_start;
        port_start = snap.port_begin;
        port_len   = snap.srv_slash - snap.port_begin;
      end
    end

    status_nxt    = snap.fail;
    out_tdata_nxt = '0;
    if (!snap.fail) begin
      out_tdata_nxt[hrlp_pkg::OUT_FIELDS_W-1:0] = {
        port_len,
        port_start[OW-1:0],
        srv_len,
        snap.srv_found ? snap.srv_start[OW-1:0] : {OW{1'b0}},
        snap.srv_found,
        snap.prot_len,
        snap.prot_start[OW-1:0],
        path_len,
        path_start[OW-1:0],
        snap.cmd_len,
        snap.cmd_start[OW-1:0]
      };
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_free) begin
      out_tvalid_r <= fin_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_take) begin
      out_tdata_r <= out_tdata_nxt;
      status_r    <= status_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = status_r;

endmodule

FILE: rtl/hrlp_chk.sv
// Port-level checks on the request line parser, bound to the top level.
`include "assert_macros.svh"

module hrlp_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [hrlp_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic [0:0]                        out_tuser
);

  `HRLP_ASSERT_ALWAYS(a_rst_empty, clk, !rst_n |=> !out_tvalid, "result beat right after reset")
  `HRLP_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result beat changed")
  `HRLP_ASSERT(a_fail_zero, clk, rst_n, out_tvalid && out_tuser[0] |-> out_tdata == '0, "failed line carries nonzero fields")
  `HRLP_ASSERT(a_no_srv_zero, clk, rst_n, out_tvalid && !out_tdata[63] |-> out_tdata[111:64] == '0, "server or port fields without server")

endmodule

bind http_request_line_parser_top hrlp_chk u_hrlp_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
